// ===== hw/rtl/stepper_move_controller_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Stepper move controller assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STEPPER_MOVE_CONTROLLER_UNIT_MACROS_SVH
`define STEPPER_MOVE_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define SMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

`define SMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`else

`define SMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define SMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper move controller package
// Payload types, command kinds, register indexes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

	localparam int POSITION_BITS = 32;
	localparam int TICKS_W       = 48;
	localparam int STABLE_W      = 24;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_GOTO  = 3'd1;
	localparam logic [2:0] KIND_MOVE  = 3'd2;
	localparam logic [2:0] KIND_DWELL = 3'd3;
	localparam logic [2:0] KIND_ABORT = 3'd4;
	localparam logic [2:0] KIND_STEP  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd2;

	localparam logic [STABLE_W-1:0] DEBOUNCE_RESET     = 24'd10000;
	localparam logic [31:0]         TIMEOUT_RESET      = 32'(1000000 * 30);
	localparam logic                ACTIVE_LEVEL_RESET = 1'b0;
	localparam logic [STABLE_W-1:0] STABLE_MAX         = '1;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] angle;
		logic [15:0]        rate;
		logic signed [31:0] wait_count;
		logic [15:0]        wait_unit;
		logic               endstop_a_level;
		logic               endstop_b_level;
	} smc_in_t;

	typedef struct packed {
		logic [15:0]        step_rate;
		logic               direction_positive;
		logic               busy_res;
		logic signed [31:0] position;
		logic               endstop_active;
		logic               timed_out;
		logic               rejected;
	} smc_out_t;

	typedef struct packed {
		logic [STABLE_W-1:0] debounce_ticks;
		logic [31:0]         timeout_ticks;
		logic                endstop_active_level;
	} smc_cfg_t;

	typedef struct packed {
		logic engaged;
		logic engaged_nxt;
	} smc_deb_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stepper_move_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Stepper move controller unit
// Single-axis stepper position controller with debounced endstops,
// command timeout and dwell.
// ----------------------------------------------------------------------------
// One transaction per clock while the output is not stalled: every input
// transaction is registered (stage 1), the axis state is updated in a single
// combinational pass in the core, and the result is registered (stage 2) when
// the stage 1 item fires. The rate is set by that single-pass state update;
// the input side stalls only while a finished result is held by a stalled
// output. Configuration writes are taken every cycle (ready is always high)
// and are meant to happen while the unit is idle.
`default_nettype none

module stepper_move_controller_unit #(
	parameter int POSITION_BITS = smc_pkg::POSITION_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire smc_pkg::smc_in_t                 in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output smc_pkg::smc_out_t                     out_data,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [smc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [smc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	smc_pkg::smc_cfg_t cfg_q;

	logic              valid_s1;
	smc_pkg::smc_in_t  item_s1;
	logic              valid_s2;
	smc_pkg::smc_out_t result_s2;

	logic              advance;
	logic              fire;
	logic              accept;
	smc_pkg::smc_out_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks       <= smc_pkg::DEBOUNCE_RESET;
			cfg_q.timeout_ticks        <= smc_pkg::TIMEOUT_RESET;
			cfg_q.endstop_active_level <= smc_pkg::ACTIVE_LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				smc_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_ticks <= cfg_data[smc_pkg::STABLE_W-1:0];
				end
				smc_pkg::REG_TIMEOUT: begin
					cfg_q.timeout_ticks <= cfg_data[31:0];
				end
				smc_pkg::REG_ACTIVE_LEVEL: begin
					cfg_q.endstop_active_level <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
			valid_s2 <= fire || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			result_s2 <= res;
		end
	end

	smc_core #(
		.POS_W (POSITION_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/smc_debounce.sv =====
// ----------------------------------------------------------------------------
// Endstop debouncer
// Accepts a new endstop level once it has been stable longer than the
// programmed debounce time, counted in ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_debounce (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tick,
	input  wire logic                          level,
	input  wire logic [smc_pkg::STABLE_W-1:0]  debounce_ticks,
	input  wire logic                          active_level,
	output smc_pkg::smc_deb_t                  st
);

	logic                         changed_q, changed_n;
	logic                         last_q, last_n;
	logic [smc_pkg::STABLE_W-1:0] stable_q, stable_n;
	logic                         engaged_q, engaged_n;

	always_comb begin
		changed_n = changed_q;
		last_n    = last_q;
		stable_n  = stable_q;
		engaged_n = engaged_q;
		if (tick) begin
			if (level != last_q) begin
				changed_n = 1'b1;
				last_n    = level;
				stable_n  = '0;
			end else if (stable_q != smc_pkg::STABLE_MAX) begin
				stable_n = stable_q + 1'b1;
			end
			if (changed_n && (stable_n > debounce_ticks)) begin
				changed_n = 1'b0;
				engaged_n = (level == active_level);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b1;
			last_q    <= 1'b1;
			stable_q  <= '0;
			engaged_q <= 1'b0;
		end else begin
			changed_q <= changed_n;
			last_q    <= last_n;
			stable_q  <= stable_n;
			engaged_q <= engaged_n;
		end
	end

	assign st.engaged     = engaged_q;
	assign st.engaged_nxt = engaged_n;

endmodule

`default_nettype wire

// ===== hw/rtl/smc_core.sv =====
// ----------------------------------------------------------------------------
// Stepper move controller core
// Axis state and the single-pass update for one transaction: commands,
// deadline countdown, step pulses and both endstop debouncers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stepper_move_controller_unit_macros.svh"

module smc_core #(
	parameter int POS_W = smc_pkg::POSITION_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire smc_pkg::smc_in_t  item,
	input  wire smc_pkg::smc_cfg_t cfg,
	output smc_pkg::smc_out_t      res
);

	localparam int TW = smc_pkg::TICKS_W;

	logic [POS_W-1:0] pos_q, pos_d;
	logic [POS_W-1:0] tgt_q, tgt_d;
	logic             finished_q, finished_d;
	logic             dwelling_q, dwelling_d;
	logic             dir_q, dir_d;
	logic [TW-1:0]    rem_q, rem_d;
	logic [15:0]      rate_q, rate_d;

	logic             tick;
	logic             engaged_pre;
	logic [POS_W-1:0] ang;
	logic [POS_W-1:0] motion_tgt;
	logic [31:0]      mag;
	logic [TW-1:0]    dwell_ticks;
	logic [TW-1:0]    rem_dec;
	logic             start;
	logic             timed_out;
	logic             rejected;

	smc_pkg::smc_deb_t deb_a, deb_b;

	assign tick = fire && (item.kind == smc_pkg::KIND_TICK);

	smc_debounce u_deb_a (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick),
		.level          (item.endstop_a_level),
		.debounce_ticks (cfg.debounce_ticks),
		.active_level   (cfg.endstop_active_level),
		.st             (deb_a)
	);

	smc_debounce u_deb_b (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick),
		.level          (item.endstop_b_level),
		.debounce_ticks (cfg.debounce_ticks),
		.active_level   (cfg.endstop_active_level),
		.st             (deb_b)
	);

	assign engaged_pre = deb_a.engaged | deb_b.engaged;
	assign ang         = POS_W'(item.angle);
	assign motion_tgt  = (item.kind == smc_pkg::KIND_GOTO) ? ang : (pos_q + ang);
	assign mag         = item.wait_count[31] ? (32'd0 - 32'(item.wait_count))
	                                         : 32'(item.wait_count);
	assign dwell_ticks = TW'(mag) * TW'(item.wait_unit);
	assign rem_dec     = (rem_q != '0) ? (rem_q - 1'b1) : rem_q;

	always_comb begin
		pos_d      = pos_q;
		tgt_d      = tgt_q;
		finished_d = finished_q;
		dwelling_d = dwelling_q;
		dir_d      = dir_q;
		rem_d      = rem_q;
		rate_d     = rate_q;
		start      = 1'b0;
		timed_out  = 1'b0;
		rejected   = 1'b0;
		case (item.kind)
			smc_pkg::KIND_TICK: begin
				if (!finished_q) begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						timed_out  = !dwelling_q;
						rate_d     = '0;
						finished_d = 1'b1;
					end
				end
			end
			smc_pkg::KIND_GOTO: begin
				if (engaged_pre) begin
					rejected = 1'b1;
				end else begin
					if ($signed(pos_q) > $signed(ang)) begin
						dir_d = 1'b0;
					end else if ($signed(pos_q) < $signed(ang)) begin
						dir_d = 1'b1;
					end
					start = 1'b1;
				end
			end
			smc_pkg::KIND_MOVE: begin
				if (engaged_pre) begin
					rejected = 1'b1;
				end else begin
					dir_d = ($signed(ang) > $signed(POS_W'(0)));
					start = 1'b1;
				end
			end
			smc_pkg::KIND_DWELL: begin
				if (engaged_pre) begin
					rejected = 1'b1;
				end else begin
					dwelling_d = 1'b1;
					rem_d      = dwell_ticks;
					finished_d = 1'b0;
					rate_d     = '0;
				end
			end
			smc_pkg::KIND_ABORT: begin
				rate_d     = '0;
				finished_d = 1'b1;
			end
			smc_pkg::KIND_STEP: begin
				pos_d = dir_q ? (pos_q + 1'b1) : (pos_q - 1'b1);
				if ((pos_d == tgt_q) || engaged_pre) begin
					rate_d     = '0;
					finished_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (start) begin
			dwelling_d = 1'b0;
			if (motion_tgt != pos_q) begin
				tgt_d      = motion_tgt;
				rem_d      = TW'(cfg.timeout_ticks);
				finished_d = 1'b0;
				rate_d     = item.rate;
			end else begin
				rate_d     = '0;
				finished_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			tgt_q      <= '0;
			finished_q <= 1'b1;
			dwelling_q <= 1'b0;
			dir_q      <= 1'b0;
			rem_q      <= '0;
			rate_q     <= '0;
		end else if (fire) begin
			pos_q      <= pos_d;
			tgt_q      <= tgt_d;
			finished_q <= finished_d;
			dwelling_q <= dwelling_d;
			dir_q      <= dir_d;
			rem_q      <= rem_d;
			rate_q     <= rate_d;
		end
	end

	assign res.step_rate          = rate_d;
	assign res.direction_positive = dir_d;
	assign res.busy_res           = !finished_d;
	assign res.position           = 32'(signed'(pos_d));
	assign res.endstop_active     = deb_a.engaged_nxt | deb_b.engaged_nxt;
	assign res.timed_out          = timed_out;
	assign res.rejected           = rejected;

	`SMC_ASSERT_NOW(a_idle_no_rate, clk, arst_n, finished_q, rate_q == '0)
	`SMC_ASSERT_NOW(a_dwell_no_rate, clk, arst_n, dwelling_q, rate_q == '0)
	`SMC_ASSERT_NOW(a_timeout_tick_only, clk, arst_n, timed_out, (item.kind == smc_pkg::KIND_TICK) && !rejected)
	`SMC_ASSERT_NEXT(a_reject_holds_axis, clk, arst_n, fire && rejected, $stable(pos_q) && $stable(tgt_q) && $stable(rem_q))

endmodule

`default_nettype wire

// ===== dv/stepper_move_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Stepper move controller unit testbench
// Feeds ticks, go-to, move, dwell, abort and step transactions with random
// gaps and output stalls, predicts every status word and compares each field.
// Endstop debounce, timeouts, rejection and the register extremes are covered.
// ----------------------------------------------------------------------------
module stepper_move_controller_unit_tb;
	import smc_pkg::*;

	localparam logic [2:0]  KIND_SPARE_LO = 3'd6;
	localparam logic [2:0]  KIND_SPARE_HI = 3'd7;
	localparam int unsigned RUN_LIMIT     = 1_000_000;
	localparam int unsigned HOLD_CYCLES   = 96;

	typedef struct packed {
		bit        changed;
		bit        last;
		bit        engaged;
		bit [23:0] stable;
	} pin_filter_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	smc_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	smc_out_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	stepper_move_controller_unit DUT (
		.clk, .arst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
		.out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("status: fail");
		$finish;
	end

	// axis model
	bit [31:0]   axis_pos, axis_target;
	bit          cmd_done, in_dwell, heading_up;
	bit [47:0]   ticks_left;
	bit [15:0]   drive_rate;
	pin_filter_t pin_a, pin_b;
	bit [23:0]   deb_limit;
	bit [31:0]   move_timeout;
	bit          engage_level;

	smc_in_t     pending[$];
	smc_out_t    status_q[$];
	int unsigned in_seen, out_seen;
	int unsigned errors, n_timeouts, n_rejects, n_engaged;
	bit          hold_req = 1'b0;

	function automatic void clear_model();
		axis_pos     = '0;
		axis_target  = '0;
		cmd_done     = 1'b1;
		in_dwell     = 1'b0;
		heading_up   = 1'b0;
		ticks_left   = '0;
		drive_rate   = '0;
		pin_a        = '{changed: 1'b1, last: 1'b1, engaged: 1'b0, stable: '0};
		pin_b        = pin_a;
		deb_limit    = DEBOUNCE_RESET;
		move_timeout = TIMEOUT_RESET;
		engage_level = ACTIVE_LEVEL_RESET;
	endfunction

	function automatic void filter_pin(input bit lv, inout pin_filter_t f);
		if (lv != f.last) begin
			f.changed = 1'b1;
			f.last    = lv;
			f.stable  = '0;
		end else if (f.stable != STABLE_MAX) begin
			f.stable++;
		end
		if (f.changed && f.stable > deb_limit) begin
			f.changed = 1'b0;
			f.engaged = (lv == engage_level);
		end
	endfunction

	function automatic void halt();
		drive_rate = '0;
		cmd_done   = 1'b1;
	endfunction

	function automatic void aim(input bit [31:0] target, input bit [15:0] rate);
		in_dwell = 1'b0;
		if (target != axis_pos) begin
			axis_target = target;
			ticks_left  = 48'(move_timeout);
			cmd_done    = 1'b0;
			drive_rate  = rate;
		end else begin
			halt();
		end
	endfunction

	function automatic smc_out_t status_after(input smc_in_t t);
		smc_out_t  r;
		bit        blocked;
		bit [31:0] mag;
		r = '0;
		blocked = pin_a.engaged || pin_b.engaged;
		if (t.kind == KIND_TICK) begin
			filter_pin(t.endstop_a_level, pin_a);
			filter_pin(t.endstop_b_level, pin_b);
			if (!cmd_done) begin
				if (ticks_left != 0)
					ticks_left--;
				if (ticks_left == 0) begin
					r.timed_out = !in_dwell;
					halt();
				end
			end
		end else if ((t.kind == KIND_GOTO || t.kind == KIND_MOVE || t.kind == KIND_DWELL)
				&& blocked) begin
			r.rejected = 1'b1;
		end else if (t.kind == KIND_GOTO) begin
			if ($signed(axis_pos) > t.angle)
				heading_up = 1'b0;
			else if ($signed(axis_pos) < t.angle)
				heading_up = 1'b1;
			aim(t.angle, t.rate);
		end else if (t.kind == KIND_MOVE) begin
			heading_up = (t.angle > 0);
			aim(axis_pos + t.angle, t.rate);
		end else if (t.kind == KIND_DWELL) begin
			mag        = t.wait_count[31] ? -t.wait_count : t.wait_count;
			in_dwell   = 1'b1;
			ticks_left = 48'(mag) * 48'(t.wait_unit);
			cmd_done   = 1'b0;
			drive_rate = '0;
		end else if (t.kind == KIND_ABORT) begin
			halt();
		end else if (t.kind == KIND_STEP) begin
			axis_pos = heading_up ? axis_pos + 1 : axis_pos - 1;
			if (axis_pos == axis_target || blocked)
				halt();
		end
		r.step_rate          = drive_rate;
		r.direction_positive = heading_up;
		r.busy_res           = !cmd_done;
		r.position           = axis_pos;
		r.endstop_active     = pin_a.engaged || pin_b.engaged;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t mismatch on %s: expected %h, got %h", $time, name, want, got);
		end
	endfunction

	function automatic int unsigned draw_gap(inout int unsigned burst);
		if (burst != 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// monitor: register writes, accepted transactions, status words
	always @(posedge clk) begin
		smc_out_t want;
		if (!arst_n) begin
			clear_model();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE:     deb_limit    = cfg_data[23:0];
					REG_TIMEOUT:      move_timeout = cfg_data;
					REG_ACTIVE_LEVEL: engage_level = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				status_q.push_back(status_after(in_data));
				in_seen++;
			end
			if (out_valid && !out_stall) begin
				out_seen++;
				if (status_q.size() == 0) begin
					errors++;
					$display("%0t unexpected status word %h", $time, out_data);
				end else begin
					want = status_q.pop_front();
					check_field("step_rate", want.step_rate, out_data.step_rate);
					check_field("direction_positive", want.direction_positive,
						out_data.direction_positive);
					check_field("busy_res", want.busy_res, out_data.busy_res);
					check_field("position", want.position, out_data.position);
					check_field("endstop_active", want.endstop_active,
						out_data.endstop_active);
					check_field("timed_out", want.timed_out, out_data.timed_out);
					check_field("rejected", want.rejected, out_data.rejected);
					n_timeouts += want.timed_out;
					n_rejects  += want.rejected;
					n_engaged  += want.endstop_active;
				end
			end
		end
	end

	// driver
	int unsigned in_next, in_gap, in_burst;
	always @(negedge clk) begin
		if (arst_n && !(in_valid && in_seen != in_next)) begin
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (in_next < pending.size()) begin
				in_data  <= pending[in_next];
				in_valid <= 1'b1;
				in_next++;
				in_gap = draw_gap(in_burst);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	int unsigned out_taken, out_wait, out_burst, hold_left;
	bit          hold_started;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_seen != out_taken) begin
				out_taken = out_seen;
				out_wait  = draw_gap(out_burst);
			end
			if (hold_req && !hold_started) begin
				hold_started = 1'b1;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (out_wait != 0) begin
				out_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic smc_in_t cmd_item(input logic [2:0] k, input logic [31:0] ang = '0,
			input logic [15:0] r = '0, input logic [31:0] wc = '0,
			input logic [15:0] wu = '0, input bit a = 1'b1, input bit b = 1'b1);
		smc_in_t t;
		t.kind            = k;
		t.angle           = ang;
		t.rate            = r;
		t.wait_count      = wc;
		t.wait_unit       = wu;
		t.endstop_a_level = a;
		t.endstop_b_level = b;
		return t;
	endfunction

	function automatic void push_tick(input bit a, input bit b, input int unsigned n);
		repeat (n) pending.push_back(cmd_item(KIND_TICK, '0, '0, '0, '0, a, b));
	endfunction

	function automatic smc_in_t motion_cmd();
		logic [31:0] dest;
		dest = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 48)) - 32'd24;
		return cmd_item($urandom_range(0, 1) ? KIND_GOTO : KIND_MOVE, dest, 16'($urandom()));
	endfunction

	function automatic smc_in_t dwell_cmd();
		logic [31:0] wc;
		logic [15:0] wu;
		wc = ($urandom_range(0, 5) == 0) ? $urandom() : 32'($urandom_range(0, 10)) - 32'd5;
		wu = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
		return cmd_item(KIND_DWELL, $urandom(), 16'($urandom()), wc, wu);
	endfunction

	function automatic smc_in_t some_command();
		case ($urandom_range(0, 3))
			0: return motion_cmd();
			1: return dwell_cmd();
			2: return cmd_item(KIND_ABORT);
			default: return cmd_item(KIND_STEP);
		endcase
	endfunction

	function automatic void random_episode(input bit [23:0] deb, input bit lvl);
		int unsigned pick, hold;
		bit          on_a, on_b;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			pending.push_back(motion_cmd());
			repeat ($urandom_range(4, 24)) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					pending.push_back(cmd_item(KIND_STEP));
				else if (pick < 92)
					push_tick(lvl ~^ ($urandom_range(0, 19) != 0), !lvl, 1);
				else if (pick < 96)
					pending.push_back(cmd_item(KIND_ABORT));
				else
					pending.push_back(motion_cmd());
			end
		end else if (pick < 65) begin
			pending.push_back(dwell_cmd());
			repeat ($urandom_range(0, 14)) begin
				if ($urandom_range(0, 7) == 0)
					pending.push_back(cmd_item(KIND_STEP));
				else
					push_tick(!lvl, !lvl, 1);
			end
		end else if (pick < 82) begin
			on_a = $urandom_range(0, 1);
			on_b = !on_a || $urandom_range(0, 1);
			hold = (deb < 64) ? deb + 1 + $urandom_range(0, 3) : $urandom_range(2, 8);
			repeat (hold) begin
				// occasional bounce back to the idle level
				if ($urandom_range(0, 9) == 0)
					push_tick(!lvl, !lvl, 1);
				else
					push_tick(on_a ? lvl : !lvl, on_b ? lvl : !lvl, 1);
				if ($urandom_range(0, 2) == 0)
					pending.push_back(some_command());
			end
			repeat ($urandom_range(1, 4)) pending.push_back(some_command());
			repeat (hold + 1) begin
				push_tick(!lvl, !lvl, 1);
				if ($urandom_range(0, 3) == 0)
					pending.push_back(some_command());
			end
		end else begin
			pending.push_back(cmd_item(3'($urandom_range(0, 7)), $urandom(), 16'($urandom()),
				$urandom(), 16'($urandom()), 1'($urandom()), 1'($urandom())));
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (in_seen != pending.size() || status_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(input bit [23:0] deb, input bit [31:0] tmo, input bit lvl,
			input int unsigned count, input bit squeeze);
		int unsigned stop_at;
		settle();
		write_reg(REG_DEBOUNCE, 32'(deb));
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_ACTIVE_LEVEL, 32'(lvl));
		if (squeeze)
			hold_req <= 1'b1;
		stop_at = pending.size() + count;
		while (pending.size() < stop_at) random_episode(deb, lvl);
		if (deb < 64)
			push_tick(!lvl, !lvl, deb + 2);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero-length commands, reaching a target, idle step, dwell
		pending.push_back(cmd_item(KIND_TICK));
		pending.push_back(cmd_item(KIND_GOTO));
		pending.push_back(cmd_item(KIND_MOVE, '0, 16'hFFFF));
		pending.push_back(cmd_item(KIND_GOTO, 32'd2, 16'hFFFF));
		repeat (2) pending.push_back(cmd_item(KIND_STEP));
		pending.push_back(cmd_item(KIND_MOVE, -32'sd2, 16'd1));
		pending.push_back(cmd_item(KIND_STEP));
		pending.push_back(cmd_item(KIND_ABORT));
		pending.push_back(cmd_item(KIND_STEP));
		pending.push_back(cmd_item(KIND_GOTO, 32'h8000_0000, 16'h8000));
		pending.push_back(cmd_item(KIND_DWELL, '0, '0, 32'h8000_0000, 16'hFFFF));
		pending.push_back(cmd_item(KIND_ABORT));
		pending.push_back(cmd_item(KIND_DWELL, '0, '0, 32'hFFFF_FFFE, 16'd1));
		push_tick(1'b1, 1'b1, 2);
		pending.push_back(cmd_item(KIND_DWELL, '0, '0, 32'h7FFF_FFFF, 16'd0));
		push_tick(1'b1, 1'b1, 1);
		pending.push_back(cmd_item(KIND_SPARE_LO, $urandom(), 16'($urandom())));
		pending.push_back(cmd_item(KIND_SPARE_HI, $urandom(), 16'($urandom())));

		// one-tick timeout, endstop A engaged, rejection, step into the endstop
		settle();
		write_reg(REG_DEBOUNCE, 32'd1);
		write_reg(REG_TIMEOUT, 32'd1);
		write_reg(REG_ACTIVE_LEVEL, 32'd0);
		pending.push_back(cmd_item(KIND_GOTO, -32'sd5, 16'd7));
		push_tick(1'b1, 1'b1, 1);
		push_tick(1'b0, 1'b1, 3);
		pending.push_back(cmd_item(KIND_GOTO, 32'd4, 16'd9));
		pending.push_back(cmd_item(KIND_STEP));
		push_tick(1'b1, 1'b1, 3);

		run_phase(24'd0, 32'd40, 1'b0, 110, 1'b0);
		run_phase(24'd5, 32'd0, 1'b1, 90, 1'b0);
		run_phase(24'd3, 32'hFFFF_FFFF, 1'b1, 100, 1'b1);
		run_phase(24'd1, 32'd25, 1'b0, 100, 1'b0);
		run_phase(24'hFF_FFFF, 32'd12, 1'b0, 80, 1'b0);
		settle();

		$display("%0d transactions sent, %0d status words checked, %0d mismatches",
			in_seen, out_seen, errors);
		$display("seen: %0d timeouts, %0d rejected commands, %0d words with an endstop engaged",
			n_timeouts, n_rejects, n_engaged);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/smc_pkg.sv
hw/rtl/smc_debounce.sv
hw/rtl/smc_core.sv
hw/rtl/stepper_move_controller_unit.sv
dv/stepper_move_controller_unit_tb.sv
